### sv/gtsd_pkg.sv
// Package for the Greek transliteration stream decoder: pending-letter mode
// codes, result word types and the single-letter and rough-breathing maps.
// Depends on nothing; used by every module of the block.
`default_nettype none

package gtsd_pkg;

   typedef enum logic [3:0] {
      MODE_IDLE  = 4'd0,
      MODE_H_LO  = 4'd1,
      MODE_H_UP  = 4'd2,
      MODE_C_LO  = 4'd3,
      MODE_C_UP  = 4'd4,
      MODE_P_LO  = 4'd5,
      MODE_P_UP  = 4'd6,
      MODE_T_LO  = 4'd7,
      MODE_T_UP  = 4'd8,
      MODE_N_LO  = 4'd9,
      MODE_N_UP  = 4'd10,
      MODE_R_LO  = 4'd11,
      MODE_R_UP  = 4'd12,
      MODE_S_LO  = 4'd13,
      MODE_NC_LO = 4'd14,
      MODE_NC_UP = 4'd15
   } mode_type;

   localparam logic KIND_CHAR  = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   typedef logic [12:0] cp_type;

   typedef struct packed {
      cp_type code_point;
      logic   is_error;
      logic   last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
      mode_type   next_mode;
   } dec_type;

   function automatic cp_type letter_map(input logic [7:0] c);
      cp_type r;
      case (c)
         "a":   r = 13'h3b1;
         "b":   r = 13'h3b2;
         "g":   r = 13'h3b3;
         "d":   r = 13'h3b4;
         "e":   r = 13'h3b5;
         "z":   r = 13'h3b6;
         8'hea: r = 13'h3b7;
         "i":   r = 13'h3b9;
         "k":   r = 13'h3ba;
         "l":   r = 13'h3bb;
         "m":   r = 13'h3bc;
         "n":   r = 13'h3bd;
         "x":   r = 13'h3be;
         "o":   r = 13'h3bf;
         "p":   r = 13'h3c0;
         "r":   r = 13'h3c1;
         "s":   r = 13'h3c2;
         "t":   r = 13'h3c4;
         "u":   r = 13'h3c5;
         "y":   r = 13'h3c5;
         "w":   r = 13'h3dd;
         8'hf4: r = 13'h3c9;
         "A":   r = 13'h391;
         "B":   r = 13'h392;
         "G":   r = 13'h393;
         "D":   r = 13'h394;
         "E":   r = 13'h395;
         "Z":   r = 13'h396;
         8'hca: r = 13'h397;
         "I":   r = 13'h399;
         "K":   r = 13'h39a;
         "L":   r = 13'h39b;
         "M":   r = 13'h39c;
         "N":   r = 13'h39d;
         "X":   r = 13'h39e;
         "O":   r = 13'h39f;
         "P":   r = 13'h3a0;
         "R":   r = 13'h3a1;
         "S":   r = 13'h3a3;
         "T":   r = 13'h3a4;
         "U":   r = 13'h3a5;
         "Y":   r = 13'h3a5;
         "W":   r = 13'h3dc;
         8'hd4: r = 13'h3a9;
         "h":   r = 13'h027;
         "H":   r = 13'h027;
         "?":   r = 13'h37e;
         ";":   r = 13'h387;
         8'hcf: r = 13'h3aa;
         8'hdc: r = 13'h3ab;
         8'hef: r = 13'h3ca;
         8'hfc: r = 13'h3cb;
         default: r = {5'b00000, c};
      endcase
      return r;
   endfunction

   function automatic cp_type rough_vowel(input logic [7:0] c, input cp_type base);
      cp_type r;
      case (c)
         "a", "A":           r = base;
         "e", "E":           r = base + 13'h010;
         8'hea, 8'hca:       r = base + 13'h020;
         "i", "I":           r = base + 13'h030;
         "o", "O":           r = base + 13'h040;
         "u", "U", "y", "Y": r = base + 13'h050;
         8'hf4, 8'hd4:       r = base + 13'h060;
         default:            r = {5'b00000, c};
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

### sv/gtsd_decode.sv
// Combinational decode of one input word against the pending-letter mode:
// gives up to two result words and the next mode.
// Depends on gtsd_pkg.
`default_nettype none

module gtsd_decode (
   input  var gtsd_pkg::mode_type mode,
   input  var logic               kind,
   input  var logic [7:0]         character,
   output var gtsd_pkg::dec_type  dec
);
   import gtsd_pkg::*;

   logic     first_v;
   cp_type   first_cp;
   logic     first_err;
   logic     second_v;
   cp_type   second_cp;
   logic     second_err;
   logic     run_second;
   mode_type mid_mode;
   mode_type nxt_mode;
   logic     is_h;
   logic     gkx;
   logic     punct;

   assign is_h  = (character == "h") || (character == "H");
   assign gkx   = (character == "g") || (character == "G") || (character == "x") ||
                  (character == "X") || (character == "k") || (character == "K");
   assign punct = (character == " ") || (character == ",") || (character == ".") ||
                  (character == "?") || (character == ";");

   always_comb begin
      first_v    = 1'b0;
      first_cp   = '0;
      first_err  = 1'b0;
      run_second = 1'b1;
      mid_mode   = MODE_IDLE;
      if (kind == KIND_FLUSH) begin
         run_second = 1'b0;
         first_v    = 1'b1;
         case (mode)
            MODE_IDLE: first_v  = 1'b0;
            MODE_N_LO: first_cp = 13'h3bd;
            MODE_N_UP: first_cp = 13'h39d;
            MODE_P_LO: first_cp = 13'h3c0;
            MODE_P_UP: first_cp = 13'h3a0;
            MODE_R_LO: first_cp = 13'h3c1;
            MODE_R_UP: first_cp = 13'h3a1;
            MODE_S_LO: first_cp = 13'h3c2;
            MODE_T_LO: first_cp = 13'h3c4;
            MODE_T_UP: first_cp = 13'h3a4;
            default:   first_err = 1'b1;
         endcase
      end else begin
         case (mode)
            MODE_N_LO: begin
               if (gkx) begin
                  first_v  = 1'b1;
                  first_cp = 13'h3b3;
               end else if (character == "c") begin
                  mid_mode   = MODE_NC_LO;
                  run_second = 1'b0;
               end else begin
                  first_v  = 1'b1;
                  first_cp = 13'h3bd;
               end
            end
            MODE_N_UP: begin
               if (gkx) begin
                  first_v  = 1'b1;
                  first_cp = 13'h393;
               end else if (character == "C") begin
                  mid_mode   = MODE_NC_UP;
                  run_second = 1'b0;
               end else begin
                  first_v  = 1'b1;
                  first_cp = 13'h39d;
               end
            end
            MODE_NC_LO: begin
               first_v  = 1'b1;
               first_cp = (character == "h") ? 13'h3b3 : 13'h3bd;
               mid_mode = MODE_C_LO;
            end
            MODE_NC_UP: begin
               first_v  = 1'b1;
               first_cp = (character == "H") ? 13'h393 : 13'h39d;
               mid_mode = MODE_C_UP;
            end
            MODE_R_LO: begin
               first_v    = 1'b1;
               first_cp   = is_h ? 13'h1fe5 : 13'h3c1;
               run_second = !is_h;
            end
            MODE_R_UP: begin
               first_v    = 1'b1;
               first_cp   = is_h ? 13'h1fec : 13'h3a1;
               run_second = !is_h;
            end
            MODE_P_LO: begin
               first_v = 1'b1;
               if (is_h) begin
                  first_cp   = 13'h3c6;
                  run_second = 1'b0;
               end else if ((character == "s") || (character == "S")) begin
                  first_cp   = 13'h3c8;
                  run_second = 1'b0;
               end else begin
                  first_cp = 13'h3c0;
               end
            end
            MODE_P_UP: begin
               first_v = 1'b1;
               if (is_h) begin
                  first_cp   = 13'h3a6;
                  run_second = 1'b0;
               end else if ((character == "s") || (character == "S")) begin
                  first_cp   = 13'h3a8;
                  run_second = 1'b0;
               end else begin
                  first_cp = 13'h3a0;
               end
            end
            MODE_S_LO: begin
               first_v  = 1'b1;
               first_cp = punct ? 13'h3c2 : 13'h3c3;
            end
            MODE_T_LO: begin
               first_v    = 1'b1;
               first_cp   = is_h ? 13'h3b8 : 13'h3c4;
               run_second = !is_h;
            end
            MODE_T_UP: begin
               first_v    = 1'b1;
               first_cp   = is_h ? 13'h398 : 13'h3a4;
               run_second = !is_h;
            end
            default: mid_mode = mode;
         endcase
      end
   end

   always_comb begin
      second_v   = 1'b0;
      second_cp  = '0;
      second_err = 1'b0;
      nxt_mode   = mid_mode;
      if (run_second) begin
         nxt_mode = MODE_IDLE;
         case (mid_mode)
            MODE_IDLE: begin
               case (character)
                  "c":     nxt_mode = MODE_C_LO;
                  "C":     nxt_mode = MODE_C_UP;
                  "h":     nxt_mode = MODE_H_LO;
                  "H":     nxt_mode = MODE_H_UP;
                  "n":     nxt_mode = MODE_N_LO;
                  "N":     nxt_mode = MODE_N_UP;
                  "p":     nxt_mode = MODE_P_LO;
                  "P":     nxt_mode = MODE_P_UP;
                  "r":     nxt_mode = MODE_R_LO;
                  "R":     nxt_mode = MODE_R_UP;
                  "s":     nxt_mode = MODE_S_LO;
                  "t":     nxt_mode = MODE_T_LO;
                  "T":     nxt_mode = MODE_T_UP;
                  default: begin
                     second_v  = 1'b1;
                     second_cp = letter_map(character);
                  end
               endcase
            end
            MODE_C_LO: begin
               second_v   = 1'b1;
               second_cp  = is_h ? 13'h3c7 : {5'b00000, character};
               second_err = !is_h;
            end
            MODE_C_UP: begin
               second_v   = 1'b1;
               second_cp  = is_h ? 13'h3a7 : {5'b00000, character};
               second_err = !is_h;
            end
            MODE_H_LO: begin
               second_v  = 1'b1;
               second_cp = rough_vowel(character, 13'h1f01);
            end
            MODE_H_UP: begin
               second_v  = 1'b1;
               second_cp = rough_vowel(character, 13'h1f09);
            end
            default: nxt_mode = MODE_IDLE;
         endcase
      end
   end

   always_comb begin
      dec.count     = {1'b0, first_v} + {1'b0, second_v};
      dec.first     = first_v ? {first_cp, first_err, !second_v}
                              : {second_cp, second_err, 1'b1};
      dec.second    = {second_cp, second_err, 1'b1};
      dec.next_mode = nxt_mode;
   end

endmodule

`default_nettype wire

### sv/gtsd_rsp_buf.sv
// Result register of the decoder: holds the one or two result words of an
// item and presents them on the result stream in order.
// Depends on gtsd_pkg.
`default_nettype none

module gtsd_rsp_buf (
   input  var logic              clock,
   input  var logic              reset,
   input  var logic              load,
   input  var gtsd_pkg::dec_type dec,
   output var logic              free,
   output var logic              rsp_tvalid,
   input  var logic              rsp_tready,
   output var logic [15:0]       rsp_tdata,   // code_point [12:0], zeros [15:13]
   output var logic              rsp_tuser,   // is_error
   output var logic              rsp_tlast    // last_of_run
);
   import gtsd_pkg::*;

   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   rsp_type    slot0_ff;
   rsp_type    slot0_in;
   rsp_type    slot1_ff;
   rsp_type    slot1_in;
   logic       take;

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign take       = rsp_tvalid && rsp_tready;
   assign free       = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && take);

   always_comb begin
      cnt_in   = cnt_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (load) begin
         cnt_in   = dec.count;
         slot0_in = dec.first;
         slot1_in = dec.second;
      end else if (take) begin
         cnt_in   = cnt_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_tdata = {3'b000, slot0_ff.code_point};
   assign rsp_tuser = slot0_ff.is_error;
   assign rsp_tlast = slot0_ff.last_of_run;

endmodule

`default_nettype wire

### sv/greek_translit_stream_decoder.sv
// Greek transliteration stream decoder, top level: input register, pending
// letter mode register and the connection of decode and result register.
// Depends on gtsd_pkg, gtsd_decode and gtsd_rsp_buf.
//
// A word accepted on the request stream is held in an input register, decoded
// combinationally against the pending-letter mode and written to the result
// register, from which its results are presented. The block takes one word per
// cycle while each word yields at most one code point and the result stream is
// ready; a word that yields two holds the result register until both are taken,
// and the input register waits meanwhile. Words that yield nothing pass through
// without using the result register. A flush word (tuser high) ends the text.
`default_nettype none

module greek_translit_stream_decoder (
   input  var logic        clock,
   input  var logic        reset,
   input  var logic        req_tvalid,
   output var logic        req_tready,
   input  var logic [7:0]  req_tdata,    // character [7:0]
   input  var logic        req_tuser,    // kind
   output var logic        rsp_tvalid,
   input  var logic        rsp_tready,
   output var logic [15:0] rsp_tdata,    // code_point [12:0], zeros [15:13]
   output var logic        rsp_tuser,    // is_error
   output var logic        rsp_tlast     // last_of_run
);
   import gtsd_pkg::*;

   logic       in_valid_ff;
   logic       in_valid_in;
   logic       in_kind_ff;
   logic [7:0] in_char_ff;
   mode_type   mode_ff;
   mode_type   mode_in;
   dec_type    dec;
   logic       buf_free;
   logic       advance;
   logic       load;

   gtsd_decode u_decode (
      .mode      (mode_ff),
      .kind      (in_kind_ff),
      .character (in_char_ff),
      .dec       (dec)
   );

   gtsd_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .dec        (dec),
      .free       (buf_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   assign advance    = in_valid_ff && ((dec.count == 2'd0) || buf_free);
   assign load       = in_valid_ff && (dec.count != 2'd0) && buf_free;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      mode_in = advance ? dec.next_mode : mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_IDLE;
      end else begin
         in_valid_ff <= in_valid_in;
         mode_ff     <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_kind_ff <= req_tuser;
         in_char_ff <= req_tdata;
      end
   end

   // The second word of a pair is already in the result register.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("second result word of an item missing");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("error word not last of its item");

   assert property (@(posedge clock) disable iff (reset)
      (advance && (in_kind_ff == KIND_FLUSH)) |=> (mode_ff == MODE_IDLE))
      else $error("pending letter survived a flush");

endmodule

`default_nettype wire
